FILE: src/regex_infix_to_postfix_core_assert.svh
// assertion macros shared by the infix to postfix converter
// no dependencies; included by files that carry concurrent checks
`ifndef REGEX_INFIX_TO_POSTFIX_CORE_ASSERT_SVH
`define REGEX_INFIX_TO_POSTFIX_CORE_ASSERT_SVH

// same-cycle implication, clocked on clock, off during reset
`define RXPF_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, off during reset
`define RXPF_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/rxpf_pkg.sv
// shared constants, character classes, precedence and control structs
// for the regex infix to postfix converter; no dependencies
package rxpf_pkg;

   localparam int STACK_DEPTH = 32;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W       = $clog2(STACK_DEPTH);

   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_BAR   = 8'h7C;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;

   localparam logic [1:0] CLS_LETTER = 2'd0;
   localparam logic [1:0] CLS_OPEN   = 2'd1;
   localparam logic [1:0] CLS_CLOSE  = 2'd2;
   localparam logic [1:0] CLS_OP     = 2'd3;

   typedef struct packed {
      logic load;
      logic emit_char;
      logic emit_top;
      logic pop;
      logic push;
      logic finalize;
   } rxpf_cmd_type;

   typedef struct packed {
      logic [1:0] in_class;
      logic       end_flag;
      logic       stack_empty;
      logic       top_is_open;
      logic       top_ge;
      logic       emit_ok;
      logic       out_ok;
   } rxpf_stat_type;

   function automatic logic [1:0] prec_of(input logic [7:0] c);
      logic [1:0] p;
      priority if (c == CH_STAR) p = 2'd3;
      else if (c == CH_DOT) p = 2'd2;
      else if (c == CH_BAR) p = 2'd1;
      else p = 2'd0;
      return p;
   endfunction

   function automatic logic [1:0] class_of(input logic [7:0] c);
      logic [1:0] k;
      priority if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == CH_HASH)
         k = CLS_LETTER;
      else if (c == CH_OPEN) k = CLS_OPEN;
      else if (c == CH_CLOSE) k = CLS_CLOSE;
      else k = CLS_OP;
      return k;
   endfunction

endpackage

FILE: src/rxpf_dp.sv
// datapath: held item, operator stack, overflow flag, pending and output registers
// depends on rxpf_pkg and regex_infix_to_postfix_core_assert.svh
`include "regex_infix_to_postfix_core_assert.svh"

module rxpf_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             req_ch,
   input  logic                   req_end_of_expr,
   input  rxpf_pkg::rxpf_cmd_type cmd,
   output rxpf_pkg::rxpf_stat_type stat,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_char,
   output logic                   rsp_has_char,
   output logic                   rsp_last,
   output logic                   rsp_overflow
);
   import rxpf_pkg::*;

   logic [7:0]       stack_ff [STACK_DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [7:0]       ch_ff;
   logic             end_ff;
   logic             pend_valid_ff, pend_valid_in;
   logic [7:0]       pend_char_ff, pend_char_in;
   logic             pend_ovf_ff, pend_ovf_in;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_char_ff, out_char_in;
   logic             out_has_ff, out_has_in;
   logic             out_last_ff, out_last_in;
   logic             out_ovf_ff, out_ovf_in;

   logic [IDX_W-1:0] top_idx;
   logic [7:0]       top_ch;
   logic             full;
   logic             emit;
   logic [7:0]       emit_val;
   logic             out_ok;

   assign top_idx  = IDX_W'(count_ff - CNT_W'(1));
   assign top_ch   = stack_ff[top_idx];
   assign full     = (count_ff == CNT_W'(STACK_DEPTH));
   assign emit     = cmd.emit_char | cmd.emit_top;
   assign emit_val = cmd.emit_top ? top_ch : ch_ff;
   assign out_ok   = !out_valid_ff || !rsp_stall;

   always_comb begin
      stat.in_class    = class_of(req_ch);
      stat.end_flag    = end_ff;
      stat.stack_empty = (count_ff == '0);
      stat.top_is_open = (top_ch == CH_OPEN);
      stat.top_ge      = (prec_of(top_ch) >= prec_of(ch_ff));
      stat.out_ok      = out_ok;
      stat.emit_ok     = !pend_valid_ff || out_ok;
   end

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
      end else if (cmd.push && !full) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.push && full) begin
         ovf_in = 1'b1;
      end else if (cmd.finalize && end_ff) begin
         ovf_in = 1'b0;
      end

      pend_valid_in = pend_valid_ff;
      pend_char_in  = pend_char_ff;
      pend_ovf_in   = pend_ovf_ff;
      if (emit) begin
         pend_valid_in = 1'b1;
         pend_char_in  = emit_val;
         pend_ovf_in   = ovf_ff;
      end else if (cmd.finalize) begin
         pend_valid_in = 1'b0;
      end

      // the newest result waits in the pending register until we know if it is last
      out_valid_in = out_valid_ff && rsp_stall;
      out_char_in  = out_char_ff;
      out_has_in   = out_has_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;
      if (emit && pend_valid_ff) begin
         out_valid_in = 1'b1;
         out_char_in  = pend_char_ff;
         out_has_in   = 1'b1;
         out_last_in  = 1'b0;
         out_ovf_in   = pend_ovf_ff;
      end else if (cmd.finalize && (pend_valid_ff || end_ff)) begin
         out_valid_in = 1'b1;
         out_char_in  = pend_valid_ff ? pend_char_ff : 8'h00;
         out_has_in   = pend_valid_ff;
         out_last_in  = end_ff;
         out_ovf_in   = pend_valid_ff ? pend_ovf_ff : ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ch_ff  <= req_ch;
         end_ff <= req_end_of_expr;
      end
      pend_char_ff <= pend_char_in;
      pend_ovf_ff  <= pend_ovf_in;
      out_char_ff  <= out_char_in;
      out_has_ff   <= out_has_in;
      out_last_ff  <= out_last_in;
      out_ovf_ff   <= out_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.push && !full) begin
         stack_ff[count_ff[IDX_W-1:0]] <= ch_ff;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_char = out_char_ff;
   assign rsp_has_char = out_has_ff;
   assign rsp_last     = out_last_ff;
   assign rsp_overflow = out_ovf_ff;

   `RXPF_ASSERT_IMP(a_count_range, 1'b1, count_ff <= CNT_W'(STACK_DEPTH), "stack count past depth")
   `RXPF_ASSERT_IMP(a_pop_nonempty, cmd.pop, count_ff != '0, "pop from empty stack")
   `RXPF_ASSERT_NXT(a_full_push_flags, cmd.push && full, ovf_ff, "dropped push left no flag")
   `RXPF_ASSERT_NXT(a_end_clears, cmd.finalize && end_ff, !ovf_ff && !pend_valid_ff && count_ff == '0,
                    "end of expression left state behind")

endmodule

FILE: src/rxpf_ctrl.sv
// controller: sequences accept, emit, pop, push, flush and finish for each item
// depends on rxpf_pkg
module rxpf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  rxpf_pkg::rxpf_stat_type stat,
   output rxpf_pkg::rxpf_cmd_type  cmd
);
   import rxpf_pkg::*;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_EMIT_CH = 3'd1;
   localparam logic [2:0] S_PUSH    = 3'd2;
   localparam logic [2:0] S_CLOSE   = 3'd3;
   localparam logic [2:0] S_POPOP   = 3'd4;
   localparam logic [2:0] S_TAIL    = 3'd5;
   localparam logic [2:0] S_FINAL   = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               unique case (stat.in_class)
                  CLS_LETTER: state_in = S_EMIT_CH;
                  CLS_OPEN:   state_in = S_PUSH;
                  CLS_CLOSE:  state_in = S_CLOSE;
                  CLS_OP:     state_in = S_POPOP;
               endcase
            end
         end
         S_EMIT_CH: begin
            if (stat.emit_ok) begin
               cmd.emit_char = 1'b1;
               state_in      = S_TAIL;
            end
         end
         S_PUSH: begin
            cmd.push = 1'b1;
            state_in = S_TAIL;
         end
         S_CLOSE: begin
            priority if (stat.stack_empty) begin
               state_in = S_TAIL;
            end else if (stat.top_is_open) begin
               // matching paren is dropped
               cmd.pop  = 1'b1;
               state_in = S_TAIL;
            end else if (stat.emit_ok) begin
               cmd.emit_top = 1'b1;
               cmd.pop      = 1'b1;
            end
         end
         S_POPOP: begin
            priority if (stat.stack_empty || !stat.top_ge) begin
               state_in = S_PUSH;
            end else if (stat.emit_ok) begin
               cmd.emit_top = 1'b1;
               cmd.pop      = 1'b1;
            end
         end
         S_TAIL: begin
            // flush the stack after the final character
            priority if (!stat.end_flag || stat.stack_empty) begin
               state_in = S_FINAL;
            end else if (stat.emit_ok) begin
               cmd.emit_top = 1'b1;
               cmd.pop      = 1'b1;
            end
         end
         S_FINAL: begin
            if (stat.out_ok) begin
               cmd.finalize = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/regex_infix_to_postfix_core.sv
// channel  ports                                        direction
// req      req_valid req_stall req_ch req_end_of_expr   in
// rsp      rsp_valid rsp_stall rsp_out_char rsp_has_char rsp_last rsp_overflow   out
//
// an item passes through idle, the state for its class, tail and final, staying in
// a pop state for each stack entry it emits; an operator also passes through push
// after its pops; the stack is accessed at most once per cycle
// reset clears the stack count, overflow flag, pending result and output valid
// stack entries are not cleared; only entries below the count are read
// a stalled rsp holds the output register; emission then waits on it
// top level: joins rxpf_ctrl and rxpf_dp; depends on rxpf_pkg
module regex_infix_to_postfix_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_ch,
   input  logic       req_end_of_expr,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_has_char,
   output logic       rsp_last,
   output logic       rsp_overflow
);
   import rxpf_pkg::*;

   rxpf_cmd_type  cmd;
   rxpf_stat_type stat;

   rxpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   rxpf_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .req_end_of_expr (req_end_of_expr),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_has_char    (rsp_has_char),
      .rsp_last        (rsp_last),
      .rsp_overflow    (rsp_overflow)
   );

endmodule

FILE: sim/regex_infix_to_postfix_core_tb.sv
// self-checking testbench for regex_infix_to_postfix_core: directed and random
// expressions, a shunting-yard predictor and a field-by-field result checker
// depends on rxpf_pkg and the core rtl
module regex_infix_to_postfix_core_tb;
   import rxpf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] out_char;
      logic       has_char;
      logic       last;
      logic       overflow;
   } postfix_item_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       eoe;
      logic       drain;
   } char_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_ch = 8'h00;
   logic       req_end_of_expr = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_has_char;
   logic       rsp_last;
   logic       rsp_overflow;

   char_item_type    char_queue[$];
   postfix_item_type exp_postfix[$];

   // predictor state
   logic [7:0] op_stk [STACK_DEPTH];
   int         depth_cnt = 0;
   logic       ovf_flag = 1'b0;

   int  n_items = 0;
   int  n_exprs = 0;
   int  n_results = 0;
   int  n_ovf_results = 0;
   int  n_errors = 0;
   bit  calm;

   regex_infix_to_postfix_core u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_ch          (req_ch),
      .req_end_of_expr (req_end_of_expr),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_has_char    (rsp_has_char),
      .rsp_last        (rsp_last),
      .rsp_overflow    (rsp_overflow)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // stretch of items with no idling on either side
   assign calm = (n_items >= 100 && n_items < 160);

   function automatic bit is_operand(logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == CH_HASH;
   endfunction

   function automatic int op_rank(logic [7:0] c);
      if (c == CH_STAR) return 3;
      if (c == CH_DOT) return 2;
      if (c == CH_BAR) return 1;
      return 0;
   endfunction

   function automatic void emit_char(logic [7:0] c);
      postfix_item_type r;
      r.out_char = c;
      r.has_char = 1'b1;
      r.last     = 1'b0;
      r.overflow = ovf_flag;
      exp_postfix = {exp_postfix, r};
   endfunction

   function automatic void push_op(logic [7:0] c);
      if (depth_cnt >= STACK_DEPTH) begin
         ovf_flag = 1'b1;
      end else begin
         op_stk[depth_cnt] = c;
         depth_cnt++;
      end
   endfunction

   function automatic void predict_postfix(logic [7:0] c, logic eoe);
      int               n;
      int               rank;
      postfix_item_type r;
      n = 0;
      if (is_operand(c)) begin
         emit_char(c);
         n++;
      end else if (c == CH_OPEN) begin
         push_op(c);
      end else if (c == CH_CLOSE) begin
         while (depth_cnt > 0 && op_stk[depth_cnt-1] != CH_OPEN) begin
            emit_char(op_stk[depth_cnt-1]);
            depth_cnt--;
            n++;
         end
         if (depth_cnt > 0) depth_cnt--;
      end else begin
         rank = op_rank(c);
         while (depth_cnt > 0 && op_rank(op_stk[depth_cnt-1]) >= rank) begin
            emit_char(op_stk[depth_cnt-1]);
            depth_cnt--;
            n++;
         end
         push_op(c);
      end
      if (eoe) begin
         while (depth_cnt > 0) begin
            emit_char(op_stk[depth_cnt-1]);
            depth_cnt--;
            n++;
         end
         if (n == 0) begin
            // nothing emitted, a bare result carries the end mark
            r.out_char = 8'h00;
            r.has_char = 1'b0;
            r.last     = 1'b1;
            r.overflow = ovf_flag;
         end else begin
            r = exp_postfix.pop_back();
            r.last = 1'b1;
         end
         exp_postfix = {exp_postfix, r};
         ovf_flag = 1'b0;
      end
   endfunction

   // stimulus helpers
   function automatic void queue_string(string s, bit eoe, bit drain);
      char_item_type it;
      for (int i = 0; i < s.len(); i++) begin
         it.ch    = s[i];
         it.eoe   = eoe && (i == s.len() - 1);
         it.drain = drain && (i == 0);
         char_queue = {char_queue, it};
         if (it.eoe) n_exprs++;
      end
   endfunction

   function automatic void queue_byte(logic [7:0] c, bit eoe);
      char_item_type it;
      it.ch    = c;
      it.eoe   = eoe;
      it.drain = 1'b0;
      char_queue = {char_queue, it};
      if (eoe) n_exprs++;
   endfunction

   function automatic string rand_operand();
      int r;
      r = $urandom_range(0, 52);
      if (r < 26) return $sformatf("%c", 8'h61 + r);
      if (r < 52) return $sformatf("%c", 8'h41 + r - 26);
      return "#";
   endfunction

   function automatic string gen_term(int lvl);
      string s;
      if (lvl > 0 && $urandom_range(0, 9) < 3) s = {"(", gen_alt(lvl - 1), ")"};
      else s = rand_operand();
      if ($urandom_range(0, 3) == 0) s = {s, "*"};
      return s;
   endfunction

   function automatic string gen_alt(int lvl);
      string s;
      int    n_alt;
      int    n_cat;
      s = "";
      n_alt = $urandom_range(1, 3);
      for (int a = 0; a < n_alt; a++) begin
         if (a > 0) s = {s, "|"};
         n_cat = $urandom_range(1, 3);
         for (int k = 0; k < n_cat; k++) begin
            if (k > 0) s = {s, "."};
            s = {s, gen_term(lvl)};
         end
      end
      return s;
   endfunction

   // deep nesting that may run past the stack depth
   function automatic void queue_deep(int opens);
      for (int i = 0; i < opens; i++) queue_byte(CH_OPEN, 1'b0);
      queue_string({rand_operand(), ".", rand_operand()}, 1'b0, 1'b0);
      for (int i = 0; i < $urandom_range(0, 4); i++) queue_byte(CH_CLOSE, 1'b0);
      queue_byte($urandom_range(0, 1) ? CH_STAR : CH_CLOSE, 1'b1);
   endfunction

   task automatic fill_stimulus();
      int    start;
      int    kind;
      int    pos;
      string s;
      // directed: letter range edges, each operator, precedence-0 bytes, parens
      queue_string("A", 1'b1, 1'b0);
      queue_string("Zaz", 1'b1, 1'b0);
      queue_string("#", 1'b1, 1'b0);
      queue_string("a|b.c*", 1'b1, 1'b0);
      queue_string("(a|b)*", 1'b1, 1'b0);
      queue_string("@[`{", 1'b1, 1'b0);
      // precedence-0 operator pops the open parens too
      queue_string("((+", 1'b1, 1'b0);
      // close with nothing stacked gives an end-only result
      queue_string(")", 1'b1, 1'b0);
      // unmatched close paren
      queue_string("a.b))", 1'b1, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'h00, 1'b1);
      queue_byte(8'h80, 1'b1);
      start = char_queue.size();
      // wait for earlier results to drain, then open more parens than the stack holds
      queue_deep(STACK_DEPTH + 2);
      char_queue[start].drain = 1'b1;
      while (char_queue.size() < 200) begin
         kind = $urandom_range(0, 99);
         if (kind < 65) begin
            queue_string(gen_alt($urandom_range(0, 3)), 1'b1, $urandom_range(0, 7) == 0);
         end else if (kind < 80) begin
            s = gen_alt($urandom_range(0, 2));
            pos = $urandom_range(0, s.len() - 1);
            if ($urandom_range(0, 1)) s[pos] = 8'($urandom_range(0, 255));
            else s = {s.substr(0, pos - 1), s.substr(pos + 1, s.len() - 1)};
            if (s.len() == 0) s = ")";
            queue_string(s, 1'b1, 1'b0);
         end else if (kind < 93) begin
            for (int i = 0; i < $urandom_range(1, 6); i++)
               queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 30);
         end else begin
            queue_deep($urandom_range(STACK_DEPTH - 3, STACK_DEPTH + 3));
         end
      end
   endtask

   // driver
   always @(posedge clock) begin
      char_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_postfix(req_ch, req_end_of_expr);
            n_items++;
         end
         if (!req_valid || !req_stall) begin
            if (char_queue.size() > 0 && char_queue[0].drain && exp_postfix.size() > 0) begin
               req_valid <= 1'b0;
            end else if (char_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 37)) begin
               nxt = char_queue.pop_front();
               req_valid       <= 1'b1;
               req_ch          <= nxt.ch;
               req_end_of_expr <= nxt.eoe;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      postfix_item_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            n_results++;
            if (rsp_overflow) n_ovf_results++;
            if (exp_postfix.size() == 0) begin
               $display("%0t: unexpected result char %h has_char %b last %b overflow %b",
                        $time, rsp_out_char, rsp_has_char, rsp_last, rsp_overflow);
               n_errors++;
            end else begin
               want = exp_postfix.pop_front();
               if (rsp_out_char !== want.out_char) begin
                  $display("%0t: out_char expected %h actual %h",
                           $time, want.out_char, rsp_out_char);
                  n_errors++;
               end
               if (rsp_has_char !== want.has_char) begin
                  $display("%0t: has_char expected %b actual %b",
                           $time, want.has_char, rsp_has_char);
                  n_errors++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last expected %b actual %b", $time, want.last, rsp_last);
                  n_errors++;
               end
               if (rsp_overflow !== want.overflow) begin
                  $display("%0t: overflow expected %b actual %b",
                           $time, want.overflow, rsp_overflow);
                  n_errors++;
               end
            end
         end
         rsp_stall <= !calm && ($urandom_range(0, 99) < 37);
      end
   end

   initial begin
      fill_stimulus();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      while (char_queue.size() > 0 || req_valid || exp_postfix.size() > 0)
         @(posedge clock);
      // room for any stray result
      repeat (80) @(posedge clock);
      $display("sent %0d characters in %0d expressions, checked %0d postfix results",
               n_items, n_exprs, n_results);
      $display("%0d results carried the overflow flag", n_ovf_results);
      if (n_errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("timeout with %0d results outstanding", exp_postfix.size());
      $display("Mismatches found");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+src
src/rxpf_pkg.sv
src/rxpf_dp.sv
src/rxpf_ctrl.sv
src/regex_infix_to_postfix_core.sv
sim/regex_infix_to_postfix_core_tb.sv
